// ===== rtl/bee_pkg.sv =====
`timescale 1ns / 1ps
package bee_pkg;

  localparam logic [7:0] BSLASH    = 8'h5C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;

  localparam logic [2:0] REG_QUOTE_COUNT = 3'd0;
  localparam logic [2:0] REG_QUOTE_A     = 3'd1;
  localparam logic [2:0] REG_QUOTE_B     = 3'd2;
  localparam logic [2:0] REG_QUOTE_C     = 3'd3;
  localparam logic [2:0] REG_QUOTE_D     = 3'd4;

  localparam int QUOTE_REGS = 4;

  typedef enum logic [1:0] {
    ESC_PLAIN = 2'd0,
    ESC_PAIR  = 2'd1,
    ESC_OCTAL = 2'd2
  } esc_kind_t;

  typedef struct packed {
    esc_kind_t  kind;
    logic [7:0] data;
    logic       eos;
  } esc_word_t;

  function automatic logic [7:0] named_letter(input logic [7:0] c);
    logic [7:0] l;
    case (c)
      8'h07:   l = 8'h61;
      8'h08:   l = 8'h62;
      8'h0C:   l = 8'h66;
      8'h0A:   l = 8'h6E;
      8'h0D:   l = 8'h72;
      8'h09:   l = 8'h74;
      8'h0B:   l = 8'h76;
      8'h1B:   l = 8'h45;
      default: l = 8'h00;
    endcase
    return l;
  endfunction

  function automatic logic [1:0] last_pos(input esc_kind_t k);
    logic [1:0] p;
    case (k)
      ESC_PLAIN: p = 2'd0;
      ESC_PAIR:  p = 2'd1;
      ESC_OCTAL: p = 2'd3;
      default:   p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/bee_front.sv =====
`timescale 1ns / 1ps
module bee_front #(
  parameter int QUOTE_SET_SIZE = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_string,
  output bee_pkg::esc_word_t word
);
  import bee_pkg::*;

  logic [2:0] quote_count_r;
  logic [7:0] quote_r [QUOTE_REGS];
  logic       quote_hit;
  logic [7:0] letter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_count_r <= 3'd0;
      for (int i = 0; i < QUOTE_REGS; i++) quote_r[i] <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUOTE_COUNT: quote_count_r <= cfg_data[2:0];
        REG_QUOTE_A:     quote_r[0] <= cfg_data;
        REG_QUOTE_B:     quote_r[1] <= cfg_data;
        REG_QUOTE_C:     quote_r[2] <= cfg_data;
        REG_QUOTE_D:     quote_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry i is live if below the count and below the set size
  always_comb begin
    quote_hit = 1'b0;
    for (int i = 0; i < QUOTE_REGS; i++) begin
      if (i < QUOTE_SET_SIZE && 4'(i) < {1'b0, quote_count_r} && quote_r[i] == in_byte)
        quote_hit = 1'b1;
    end
  end

  assign letter = named_letter(in_byte);

  always_comb begin
    word.eos = in_end_of_string;
    if (in_byte == BSLASH) begin
      word.kind = ESC_PAIR;
      word.data = BSLASH;
    end else if (in_byte < PRINT_LO || in_byte > PRINT_HI) begin
      if (letter != 8'h00) begin
        word.kind = ESC_PAIR;
        word.data = letter;
      end else begin
        word.kind = ESC_OCTAL;
        word.data = in_byte;
      end
    end else if (quote_hit) begin
      word.kind = ESC_PAIR;
      word.data = in_byte;
    end else begin
      word.kind = ESC_PLAIN;
      word.data = in_byte;
    end
  end

endmodule

// ===== rtl/bee_queue.sv =====
`timescale 1ns / 1ps
module bee_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bee_pkg::esc_word_t push_word,
  output logic               full,
  output logic               valid,
  output bee_pkg::esc_word_t head,
  input  logic               pop
);
  import bee_pkg::*;

  esc_word_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/bee_back.sv =====
`timescale 1ns / 1ps
module bee_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  bee_pkg::esc_word_t q_head,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  output logic               out_string_last
);
  import bee_pkg::*;

  logic [1:0] pos_r;
  logic [1:0] pos_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_run_last_r;
  logic       out_string_last_r;
  logic       load;
  logic       at_end;
  logic [7:0] cur_byte;
  logic [2:0] digit;

  assign load   = q_valid && (!out_valid_r || out_pop);
  assign at_end = (pos_r == last_pos(q_head.kind));
  assign q_pop  = load && at_end;
  assign pos_nxt = at_end ? 2'd0 : pos_r + 2'd1;

  always_comb begin
    case (pos_r)
      2'd1:    digit = {1'b0, q_head.data[7:6]};
      2'd2:    digit = q_head.data[5:3];
      default: digit = q_head.data[2:0];
    endcase
  end

  always_comb begin
    case (q_head.kind)
      ESC_PLAIN: cur_byte = q_head.data;
      ESC_PAIR:  cur_byte = (pos_r == 2'd0) ? BSLASH : q_head.data;
      ESC_OCTAL: cur_byte = (pos_r == 2'd0) ? BSLASH : CHAR_ZERO + {5'd0, digit};
      default:   cur_byte = q_head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r        <= cur_byte;
      out_run_last_r    <= at_end;
      out_string_last_r <= at_end && q_head.eos;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_run_last_r;
  assign out_string_last = out_string_last_r;

`ifndef NO_ASSERTIONS
  a_string_last_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_string_last_r |-> out_run_last_r)
    else $error("string_last without run_last");

  a_mid_word_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd0 |-> q_valid)
    else $error("expansion in progress with empty queue");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> pos_r <= last_pos(q_head.kind))
    else $error("position past end of expansion");

  a_pop_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> pos_r == 2'd0)
    else $error("position not cleared after pop");
`endif

endmodule

// ===== rtl/backslash_escape_encoder_top.sv =====
`timescale 1ns / 1ps
// an accepted input word is stored in the queue, then in the output byte register
// throughput: one output word per cycle while pop is held and words are queued;
// an input yields 1, 2 or 4 words (4 for octal escapes) via the single output byte register
// a two-word queue separates classification from output sequencing
// reset: synchronous active low, clears queue, output and quote registers
module backslash_escape_encoder_top #(
  parameter int QUOTE_SET_SIZE = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_last
);
  import bee_pkg::*;

  esc_word_t front_word;
  esc_word_t q_head;
  logic      q_valid;
  logic      q_pop;

  bee_front #(.QUOTE_SET_SIZE(QUOTE_SET_SIZE)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .word             (front_word)
  );

  bee_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (front_word),
    .full      (full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  bee_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_empty       (empty),
    .out_pop         (pop),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

endmodule
